>>> design/weighted_median_sort_scan_macros.svh
// ----------------------------------------------------------------------------
// Weighted median sort scan - assertion macros
// Concurrent check macros that are active in simulation and empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_MEDIAN_SORT_SCAN_MACROS_SVH
`define WEIGHTED_MEDIAN_SORT_SCAN_MACROS_SVH

`ifndef SYNTHESIS
`define WMSS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("weighted median check failed");
`define WMSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("weighted median check failed");
`else
`define WMSS_ASSERT_SAME(label, ante, cons)
`define WMSS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> design/wmss_pkg.sv
// ----------------------------------------------------------------------------
// Weighted median sort scan - package
// Shared types and fixed field widths.
// ----------------------------------------------------------------------------
package wmss_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int MEDIAN_BITS = 32;
    localparam int COUNT_BITS  = 7;
    localparam int OUT_BITS    = 40;

    typedef struct packed {
        logic insert;
        logic shift;
    } wmss_ctrl_t;

endpackage

>>> design/wmss_cell.sv
// ----------------------------------------------------------------------------
// Weighted median sort scan - sorting cell
// Holds one sorted entry; takes the new word or its left neighbour's entry on
// insertion, and its right neighbour's entry while the chain drains.
// ----------------------------------------------------------------------------
module wmss_cell #(
    parameter int VALUE_BITS = 32,
    parameter int CW         = 7,
    parameter int INDEX      = 0
) (
    input  logic                    clk,
    input  wmss_pkg::wmss_ctrl_t    ctrl,
    input  logic [VALUE_BITS-1:0]   new_value,
    input  logic [CW-1:0]           count,
    input  logic [VALUE_BITS-1:0]   left_value,
    input  logic                    left_gt,
    input  logic [VALUE_BITS-1:0]   right_value,
    output logic [VALUE_BITS-1:0]   value,
    output logic                    gt
);
    import wmss_pkg::*;

    logic [VALUE_BITS-1:0] value_reg;
    logic                  occupied;

    always_comb
    begin
        occupied = (CW'(INDEX) < count);
        gt       = !occupied || (value_reg > new_value);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.insert)
        begin
            if (gt)
            begin
                value_reg <= left_gt ? left_value : new_value;
            end
        end
        else if (ctrl.shift)
        begin
            value_reg <= right_value;
        end
    end

    assign value = value_reg;

endmodule

>>> design/weighted_median_sort_scan.sv
// Scan: after the last word is taken, the drain scan walks the sorted chain one entry
//   a cycle until the half sum.
// Throughput: one word a cycle while a set fills; no word is taken during the scan.
// Reset: count, total, overflow mark, state and output valid clear at once;
//   the cell contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
// Weighted median sort scan - top level
// Insertion-sorting chain of cells with a drain scan for the weighted median.
// ----------------------------------------------------------------------------
module weighted_median_sort_scan #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [wmss_pkg::SAMPLE_BITS-1:0]   s_tdata,  // sample_value
    input  logic                               s_tlast,  // last_item
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [wmss_pkg::OUT_BITS-1:0]      m_tdata,  // median_value, set_count, zero pad
    output logic                               m_tuser   // overflow_flag
);
    import wmss_pkg::*;

    `include "weighted_median_sort_scan_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = VALUE_BITS + CW;

    typedef enum logic [1:0] {
        ST_FILL = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         remain_reg, remain_next;
    logic [TW-1:0]         total_reg, total_next;
    logic [TW-1:0]         prefix_reg, prefix_next;
    logic                  dropped_reg, dropped_next;
    logic                  out_valid_reg, out_valid_next;
    logic [MEDIAN_BITS-1:0] out_median_reg, out_median_next;
    logic [COUNT_BITS-1:0] out_count_reg, out_count_next;
    logic                  out_flag_reg, out_flag_next;

    logic [VALUE_BITS-1:0] new_value;
    logic [VALUE_BITS-1:0] cell_value [DEPTH];
    logic                  cell_gt    [DEPTH];
    wmss_ctrl_t            ctrl;
    logic                  accept;
    logic                  room;
    logic [TW-1:0]         prefix_sum;
    logic                  hit;
    logic                  emit;
    logic                  slot_free;

    assign new_value = VALUE_BITS'(s_tdata);
    assign s_tready  = (state_reg == ST_FILL);
    assign accept    = s_tvalid && s_tready;
    assign room      = (count_reg < CW'(DEPTH));
    assign slot_free = !out_valid_reg || m_tready;

    assign prefix_sum = prefix_reg + TW'(cell_value[0]);
    assign hit        = ({prefix_sum, 1'b0} >= {1'b0, total_reg}) || (remain_reg == CW'(1));
    assign emit       = (state_reg == ST_SCAN) && hit && slot_free;

    assign ctrl.insert = accept && room;
    assign ctrl.shift  = (state_reg == ST_SCAN) && !hit;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            wmss_cell #(
                .VALUE_BITS (VALUE_BITS),
                .CW         (CW),
                .INDEX      (gi)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .new_value   (new_value),
                .count       (count_reg),
                .left_value  ((gi == 0) ? new_value : cell_value[(gi == 0) ? 0 : gi - 1]),
                .left_gt     ((gi == 0) ? 1'b0 : cell_gt[(gi == 0) ? 0 : gi - 1]),
                .right_value (cell_value[(gi == DEPTH - 1) ? gi : gi + 1]),
                .value       (cell_value[gi]),
                .gt          (cell_gt[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        remain_next     = remain_reg;
        total_next      = total_reg;
        prefix_next     = prefix_reg;
        dropped_next    = dropped_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_median_next = out_median_reg;
        out_count_next  = out_count_reg;
        out_flag_next   = out_flag_reg;

        unique case (state_reg)
            ST_FILL:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CW'(1);
                        total_next = total_reg + TW'(new_value);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        remain_next = room ? count_reg + CW'(1) : count_reg;
                        prefix_next = '0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!hit)
                begin
                    prefix_next = prefix_sum;
                    remain_next = remain_reg - CW'(1);
                end
                else if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_median_next = MEDIAN_BITS'(cell_value[0]);
                    out_count_next  = COUNT_BITS'(count_reg);
                    out_flag_next   = dropped_reg;
                    count_next      = '0;
                    total_next      = '0;
                    dropped_next    = 1'b0;
                    state_next      = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            count_reg     <= '0;
            remain_reg    <= '0;
            total_reg     <= '0;
            prefix_reg    <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            total_reg     <= total_next;
            prefix_reg    <= prefix_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_median_reg <= out_median_next;
        out_count_reg  <= out_count_next;
        out_flag_reg   <= out_flag_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_BITS - MEDIAN_BITS - COUNT_BITS){1'b0}}, out_count_reg,
                       out_median_reg};
    assign m_tuser  = out_flag_reg;

    `WMSS_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `WMSS_ASSERT_SAME(a_scan_nonempty, state_reg == ST_SCAN, remain_reg != '0 && count_reg != '0)
    `WMSS_ASSERT_NEXT(a_emit_clears, emit, count_reg == '0 && total_reg == '0 && m_tvalid)

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Weighted median sort scan - testbench
// Streams sets of Q16.16 values into the block and checks each weighted median
// word against an in-bench sorting model. A short table of hand-picked sets
// comes first: extremes, zero totals, ties and unsorted order. Random sets of
// mixed size and value style follow, some of them filling or overrunning the
// store. Both stream sides stall at random, with one stretch of no stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH        = 64;
    localparam int VALUE_BITS   = 32;
    localparam int RANDOM_WORDS = 1800;
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 36;
    localparam int ROW_COUNT    = 21;

    typedef struct {
        logic [wmss_pkg::MEDIAN_BITS-1:0] median;
        logic [wmss_pkg::COUNT_BITS-1:0]  count;
        logic                             overflow;
    } median_word_t;

    typedef struct {
        logic [wmss_pkg::SAMPLE_BITS-1:0] value;
        logic                             last;
        logic                             typed;
        median_word_t                     want;
    } stim_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [wmss_pkg::SAMPLE_BITS-1:0] s_tdata = '0;
    logic                             s_tlast = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [wmss_pkg::OUT_BITS-1:0]    m_tdata;
    logic                             m_tuser;

    logic [VALUE_BITS-1:0] kept_values[$];
    logic [39:0]           kept_sum;
    logic                  spill_seen;

    median_word_t median_due_q[$];
    median_word_t due_word;
    stim_row_t    directed_rows[ROW_COUNT];
    int           error_count = 0;
    int           word_count = 0;
    int           cycle_count = 0;
    logic         calm_stretch = 1'b0;

    weighted_median_sort_scan #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    task automatic predict_median_word(input logic [31:0] value, input logic last,
                                       output logic has_word, output median_word_t word);
        logic [VALUE_BITS-1:0] v;
        logic [39:0]           prefix;
        int                    pos;
        logic                  found;
        v = value[VALUE_BITS-1:0];
        has_word = 1'b0;
        word = '{default: '0};
        if (kept_values.size() < DEPTH)
        begin
            pos = kept_values.size();
            while (pos > 0 && kept_values[pos-1] > v)
                pos--;
            kept_values.insert(pos, v);
            kept_sum = kept_sum + 40'(v);
        end
        else
            spill_seen = 1'b1;
        if (last)
        begin
            prefix = '0;
            found = 1'b0;
            for (int i = 0; i < kept_values.size(); i++)
            begin
                if (!found)
                begin
                    prefix = prefix + 40'(kept_values[i]);
                    if ((prefix << 1) >= kept_sum)
                    begin
                        word.median = 32'(kept_values[i]);
                        found = 1'b1;
                    end
                end
            end
            if (!found)
                word.median = 32'(kept_values[kept_values.size()-1]);
            word.count = 7'(kept_values.size());
            word.overflow = spill_seen;
            has_word = 1'b1;
            kept_values.delete();
            kept_sum = '0;
            spill_seen = 1'b0;
        end
    endtask

    task automatic send_word(input logic [31:0] value, input logic last,
                             output logic has_word, output median_word_t word);
        while (!calm_stretch && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        word_count++;
        predict_median_word(value, last, has_word, word);
    endtask

    task automatic send_random_set();
        int           n;
        int           shape;
        int           style;
        logic [31:0]  base;
        logic [31:0]  v;
        logic         has_word;
        median_word_t word;
        shape = $urandom_range(99);
        if (shape < 60)
            n = $urandom_range(8, 1);
        else if (shape < 80)
            n = $urandom_range(40, 9);
        else if (shape < 88)
            n = $urandom_range(DEPTH - 1, 41);
        else if (shape < 93)
            n = DEPTH;
        else
            n = $urandom_range(DEPTH + 16, DEPTH + 1);
        style = $urandom_range(5);
        base = $urandom;
        for (int i = 0; i < n; i++)
        begin
            case (style)
                0: v = $urandom;
                1: v = $urandom_range(15);
                2: v = ($urandom_range(7) == 0) ? $urandom : 32'h0;
                3: v = base;
                4: v = 32'hFFFF_FFFF - $urandom_range(3);
                default: v = base ^ (32'h1 << $urandom_range(31));
            endcase
            send_word(v, i == n - 1, has_word, word);
            if (has_word)
                median_due_q.push_back(word);
        end
    endtask

    always @(posedge clk)
        m_tready <= calm_stretch || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (median_due_q.size() == 0)
            begin
                $display("%0t: unexpected median word, expected none, actual %h/%b",
                         $time, m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                due_word = median_due_q.pop_front();
                if (m_tdata[31:0] !== due_word.median)
                begin
                    $display("%0t: median_value expected %h actual %h",
                             $time, due_word.median, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[38:32] !== due_word.count)
                begin
                    $display("%0t: set_count expected %0d actual %0d",
                             $time, due_word.count, m_tdata[38:32]);
                    error_count++;
                end
                if (m_tuser !== due_word.overflow)
                begin
                    $display("%0t: overflow_flag expected %b actual %b",
                             $time, due_word.overflow, m_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d median words outstanding",
                     $time, median_due_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic         has_word;
        median_word_t word;
        kept_sum   = '0;
        spill_seen = 1'b0;
        directed_rows[0]  = '{32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 7'd1, 1'b0}};
        directed_rows[1]  = '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 7'd1, 1'b0}};
        directed_rows[2]  = '{32'h0000_0001, 1'b1, 1'b1, '{32'h0000_0001, 7'd1, 1'b0}};
        directed_rows[3]  = '{32'h0000_0000, 1'b0, 1'b0, '{default: '0}};
        directed_rows[4]  = '{32'h0000_0000, 1'b0, 1'b0, '{default: '0}};
        directed_rows[5]  = '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 7'd3, 1'b0}};
        directed_rows[6]  = '{32'h0000_0005, 1'b0, 1'b0, '{default: '0}};
        directed_rows[7]  = '{32'h0000_0003, 1'b0, 1'b0, '{default: '0}};
        directed_rows[8]  = '{32'h0000_0005, 1'b1, 1'b0, '{default: '0}};
        directed_rows[9]  = '{32'hFFFF_FFFF, 1'b0, 1'b0, '{default: '0}};
        directed_rows[10] = '{32'hFFFF_FFFF, 1'b0, 1'b0, '{default: '0}};
        directed_rows[11] = '{32'h0000_0001, 1'b1, 1'b0, '{default: '0}};
        directed_rows[12] = '{32'h0000_0003, 1'b0, 1'b0, '{default: '0}};
        directed_rows[13] = '{32'h0000_0001, 1'b0, 1'b0, '{default: '0}};
        directed_rows[14] = '{32'h0000_0002, 1'b0, 1'b0, '{default: '0}};
        directed_rows[15] = '{32'h0000_0004, 1'b1, 1'b0, '{default: '0}};
        directed_rows[16] = '{32'h0001_0000, 1'b0, 1'b0, '{default: '0}};
        directed_rows[17] = '{32'h0000_0000, 1'b0, 1'b0, '{default: '0}};
        directed_rows[18] = '{32'h0000_0000, 1'b1, 1'b0, '{default: '0}};
        directed_rows[19] = '{32'h8000_0000, 1'b0, 1'b0, '{default: '0}};
        directed_rows[20] = '{32'h7FFF_FFFF, 1'b1, 1'b0, '{default: '0}};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < ROW_COUNT; r++)
        begin
            send_word(directed_rows[r].value, directed_rows[r].last, has_word, word);
            if (has_word)
                median_due_q.push_back(directed_rows[r].typed ? directed_rows[r].want : word);
        end

        while (word_count < ROW_COUNT + RANDOM_WORDS)
        begin
            calm_stretch = (word_count >= 700 && word_count < 1000);
            send_random_set();
        end
        calm_stretch = 1'b0;
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (median_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
